/* hw/rtl/ittp_pkg.sv */
// Shared types, constants and the precedence function for the infix to postfix converter.
// Used by ittp_stack, ittp_prec_cmp and infix_to_postfix_converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ittp_pkg;

    localparam int STACK_DEPTH  = 32;
    localparam int OPERAND_BITS = 32;

    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = $clog2(STACK_DEPTH);
    localparam int TAG_W   = 32;
    localparam int OPC_W   = 3;
    localparam int ACT_W   = 2;
    localparam int KIND_W  = 2;
    localparam int FAULT_W = 2;

    localparam int IN_TDATA_W  = ((TAG_W + OPC_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((TAG_W + OPC_W + FAULT_W + 7) / 8) * 8;

    localparam logic [63:0] OPERAND_MASK64 = (OPERAND_BITS >= 64) ? '1 :
                                             ((64'd1 << OPERAND_BITS) - 64'd1);
    localparam logic [TAG_W-1:0] OPERAND_MASK = OPERAND_MASK64[TAG_W-1:0];

    // operator codes
    localparam logic [OPC_W-1:0] OPC_OPEN  = 3'd0;
    localparam logic [OPC_W-1:0] OPC_CLOSE = 3'd1;
    localparam logic [OPC_W-1:0] OPC_ADD   = 3'd2;
    localparam logic [OPC_W-1:0] OPC_SUB   = 3'd3;
    localparam logic [OPC_W-1:0] OPC_MUL   = 3'd4;
    localparam logic [OPC_W-1:0] OPC_DIV   = 3'd5;

    // token actions
    localparam logic [ACT_W-1:0] ACT_OPERAND  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_OPERATOR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_END      = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_OPERAND  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OPERATOR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MARKER   = 2'd2;

    // fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE     = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_CLOSE    = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_OVERFLOW = 2'd2;
    localparam logic [FAULT_W-1:0] FAULT_OPEN     = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OPERAND,
        ST_POP,
        ST_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        CMP_PRIO,
        CMP_CLOSE,
        CMP_FLUSH
    } t_cmp_mode;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic [OPC_W-1:0] code;
    } t_stack_ctl;

    function automatic logic [1:0] prec(input logic [OPC_W-1:0] code);
        logic [1:0] p;
        case (code)
            OPC_OPEN:          p = 2'd1;
            OPC_ADD, OPC_SUB:  p = 2'd2;
            OPC_MUL, OPC_DIV:  p = 2'd3;
            default:           p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ittp_stack.sv */
// Operator stack: register file of operator codes with a fill count.
// Depends on ittp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ittp_stack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ittp_pkg::t_stack_ctl          i_ctl,
    output logic [ittp_pkg::OPC_W-1:0]    o_top,
    output logic [ittp_pkg::CNT_W-1:0]    o_count
);
    import ittp_pkg::*;

    logic [OPC_W-1:0] r_mem [STACK_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] top_pos;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic             full;

    assign full    = (r_count == CNT_W'(STACK_DEPTH));
    assign top_pos = r_count - CNT_W'(1);
    assign wr_idx  = r_count[IDX_W-1:0];
    assign rd_idx  = top_pos[IDX_W-1:0];

    always_comb begin
        n_count = r_count;
        if (i_ctl.push && !full) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_ctl.pop && (r_count != '0)) begin
            n_count = top_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !full) begin
            r_mem[wr_idx] <= i_ctl.code;
        end
    end

    assign o_top   = r_mem[rd_idx];
    assign o_count = r_count;

endmodule

`default_nettype wire

/* hw/rtl/ittp_prec_cmp.sv */
// Shared pop decision unit: compares the stack top against the pending token.
// Depends on ittp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ittp_prec_cmp (
    input  ittp_pkg::t_cmp_mode          i_mode,
    input  logic                         i_nonempty,
    input  logic [ittp_pkg::OPC_W-1:0]   i_top,
    input  logic [ittp_pkg::OPC_W-1:0]   i_op,
    output logic                         o_pop
);
    import ittp_pkg::*;

    always_comb begin
        case (i_mode)
            // an open paren never pops anything
            CMP_PRIO:  o_pop = i_nonempty && (i_op != OPC_OPEN) &&
                               (prec(i_top) >= prec(i_op));
            CMP_CLOSE: o_pop = i_nonempty && (i_top != OPC_OPEN);
            CMP_FLUSH: o_pop = i_nonempty;
            default:   o_pop = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/infix_to_postfix_converter.sv */
// Shunting-yard infix to postfix converter, top level with the token sequencer.
// Depends on ittp_pkg, ittp_stack and ittp_prec_cmp.
//
// Usage:
//   The slave channel takes one infix token per transfer: tuser holds the action
//   (operand, operator, end), tdata the operand tag and operator code. The master
//   channel gives postfix tokens and the end marker; tlast flags the final result
//   caused by one input token, tuser holds the result kind.
//   o_s_axis_tready is high only while the sequencer is idle; one token is worked
//   on at a time, one stack decision per cycle through a single compare unit
//   unless a result waits on a stalled receiver. Invalid tokens (unknown action,
//   or operator code above divide) give no result and leave the sequencer idle.
//   An operand result goes through the operand state, a popped operator first
//   through the pending register; an end mark first drops unmatched open parens
//   on top of the stack before its first result.
//   A single output register parts the two sides; on a receiver stall the
//   sequencer holds once a result waits there, which stretches the token in work.
//   Synchronous active-low reset empties the stack, clears the recorded fault
//   and the output valid; stack entries keep no reset value.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [31:0] operand_tag, [34:32] op_code, rest zero
    input  logic [ittp_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    // [1:0] action
    input  logic [ittp_pkg::ACT_W-1:0]            i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [31:0] out_operand, [34:32] out_op, [36:35] fault, rest zero
    output logic [ittp_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // [1:0] kind
    output logic [ittp_pkg::KIND_W-1:0]           o_m_axis_tuser,
    output logic                                  o_m_axis_tlast
);
    import ittp_pkg::*;

    t_state             r_state;
    t_state             n_state;

    logic [ACT_W-1:0]   r_action;
    logic [OPC_W-1:0]   r_op;
    logic [TAG_W-1:0]   r_tag;

    logic               r_pend_v;
    logic [OPC_W-1:0]   r_pend_code;
    logic [FAULT_W-1:0] r_sticky;

    logic               r_out_valid;
    logic [KIND_W-1:0]  r_out_kind;
    logic [TAG_W-1:0]   r_out_operand;
    logic [OPC_W-1:0]   r_out_op;
    logic [FAULT_W-1:0] r_out_fault;
    logic               r_out_last;

    logic               s_accept;
    logic               out_free;
    logic               nonempty;
    logic               full;
    logic               pop_req;
    t_cmp_mode          cmp_mode;
    t_stack_ctl         stk_ctl;
    logic [OPC_W-1:0]   top_code;
    logic [CNT_W-1:0]   stk_count;

    logic               emit;
    logic [KIND_W-1:0]  e_kind;
    logic [TAG_W-1:0]   e_operand;
    logic [OPC_W-1:0]   e_op;
    logic [FAULT_W-1:0] e_fault;
    logic               e_last;
    logic               pend_load;
    logic               pend_clear;
    logic               fault_note;
    logic [FAULT_W-1:0] fault_code;
    logic               fault_clear;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign nonempty        = (stk_count != '0);
    assign full            = (stk_count == CNT_W'(STACK_DEPTH));

    always_comb begin
        if (r_state == ST_FLUSH) begin
            cmp_mode = CMP_FLUSH;
        end else if (r_op == OPC_CLOSE) begin
            cmp_mode = CMP_CLOSE;
        end else begin
            cmp_mode = CMP_PRIO;
        end
    end

    ittp_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stk_ctl),
        .o_top   (top_code),
        .o_count (stk_count)
    );

    ittp_prec_cmp u_cmp (
        .i_mode     (cmp_mode),
        .i_nonempty (nonempty),
        .i_top      (top_code),
        .i_op       (r_op),
        .o_pop      (pop_req)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    case (i_s_axis_tuser)
                        ACT_OPERAND:  n_state = ST_OPERAND;
                        ACT_OPERATOR: begin
                            if (i_s_axis_tdata[TAG_W +: OPC_W] <= OPC_DIV) begin
                                n_state = ST_POP;
                            end
                        end
                        ACT_END:      n_state = ST_FLUSH;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_OPERAND: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_POP: begin
                if (!pop_req && (!r_pend_v || out_free)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (!nonempty && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        stk_ctl     = '0;
        emit        = 1'b0;
        e_kind      = KIND_OPERATOR;
        e_operand   = '0;
        e_op        = '0;
        e_fault     = FAULT_NONE;
        e_last      = 1'b0;
        pend_load   = 1'b0;
        pend_clear  = 1'b0;
        fault_note  = 1'b0;
        fault_code  = FAULT_NONE;
        fault_clear = 1'b0;
        case (r_state)
            ST_OPERAND: begin
                if (out_free) begin
                    emit      = 1'b1;
                    e_kind    = KIND_OPERAND;
                    e_operand = r_tag;
                    e_last    = 1'b1;
                end
            end
            ST_POP: begin
                // hold each popped code one step so the final one gets tlast
                if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        emit   = 1'b1;
                        e_op   = r_pend_code;
                        e_last = !pop_req;
                    end
                    if (pop_req) begin
                        pend_load   = 1'b1;
                        stk_ctl.pop = 1'b1;
                    end else begin
                        pend_clear = 1'b1;
                        if (r_op == OPC_CLOSE) begin
                            if (nonempty) begin
                                stk_ctl.pop = 1'b1;
                            end else begin
                                fault_note = 1'b1;
                                fault_code = FAULT_CLOSE;
                            end
                        end else if (full) begin
                            fault_note = 1'b1;
                            fault_code = FAULT_OVERFLOW;
                        end else begin
                            stk_ctl.push = 1'b1;
                            stk_ctl.code = r_op;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (pop_req) begin
                    if (top_code == OPC_OPEN) begin
                        // drop an unmatched open paren
                        stk_ctl.pop = 1'b1;
                        fault_note  = 1'b1;
                        fault_code  = FAULT_OPEN;
                    end else if (out_free) begin
                        emit        = 1'b1;
                        e_op        = top_code;
                        stk_ctl.pop = 1'b1;
                    end
                end else if (out_free) begin
                    emit        = 1'b1;
                    e_kind      = KIND_MARKER;
                    e_fault     = r_sticky;
                    e_last      = 1'b1;
                    fault_clear = 1'b1;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend_v    <= 1'b0;
            r_sticky    <= FAULT_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pend_load) begin
                r_pend_v <= 1'b1;
            end else if (pend_clear) begin
                r_pend_v <= 1'b0;
            end
            if (fault_clear) begin
                r_sticky <= FAULT_NONE;
            end else if (fault_note && (r_sticky == FAULT_NONE)) begin
                r_sticky <= fault_code;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_action <= i_s_axis_tuser;
            r_op     <= i_s_axis_tdata[TAG_W +: OPC_W];
            r_tag    <= i_s_axis_tdata[TAG_W-1:0] & OPERAND_MASK;
        end
        if (pend_load) begin
            r_pend_code <= top_code;
        end
        if (emit) begin
            r_out_kind    <= e_kind;
            r_out_operand <= e_operand;
            r_out_op      <= e_op;
            r_out_fault   <= e_fault;
            r_out_last    <= e_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - TAG_W - OPC_W - FAULT_W)'(0),
                              r_out_fault, r_out_op, r_out_operand};

    a_pend_in_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_state == ST_POP))
        else $error("pending pop held outside the pop loop");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_MARKER)) |-> r_out_last)
        else $error("end marker without tlast");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_sticky_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (e_kind == KIND_MARKER)) |=> (r_sticky == FAULT_NONE))
        else $error("fault not cleared after end marker");

    a_operand_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OPERAND) |-> (r_action == ACT_OPERAND))
        else $error("operand state entered for a non-operand token");

endmodule

`default_nettype wire

/* bench/tb_infix_to_postfix_converter.sv */
`timescale 1ns / 1ps
// Self-checking bench for infix_to_postfix_converter: a directed token table, deep nesting,
// then random infix expressions checked by a shunting-yard predictor under random stalls
// on both streams. Depends on ittp_pkg and the converter RTL.

module tb_infix_to_postfix_converter;
    import ittp_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RST_CYCLES   = 7;
    localparam int N_DIRECTED   = 25;
    localparam int N_ITEMS      = 160;
    localparam int MAX_CYCLES   = 2_000_000;
    localparam int DRAIN_CYCLES = STACK_DEPTH + 8;
    localparam int MAX_REPORTS  = 10;

    // codes the block must ignore
    localparam logic [ACT_W-1:0] ACT_BAD  = 2'd3;
    localparam logic [OPC_W-1:0] OPC_BAD6 = 3'd6;
    localparam logic [OPC_W-1:0] OPC_BAD7 = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TAG_W-1:0]   operand;
        logic [OPC_W-1:0]   op;
        logic [FAULT_W-1:0] fault;
        logic               last;
    } t_postfix_tok;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [TAG_W-1:0]   tag;
        logic [OPC_W-1:0]   op;
        logic               typed;   // result written into the table
        logic [KIND_W-1:0]  t_kind;
        logic [FAULT_W-1:0] t_fault;
        logic               drain;   // hold off until every result is back
        logic               no_gap;
    } t_infix_tok;

    logic       i_clk   = 1'b0;
    logic       rst_n   = 1'b0;
    logic       s_valid = 1'b0;
    logic       m_ready = 1'b0;
    t_infix_tok s_tok   = '0;
    logic                   s_ready;
    logic                   m_valid;
    logic                   m_last;
    logic [IN_TDATA_W-1:0]  s_data;
    logic [OUT_TDATA_W-1:0] m_data;
    logic [KIND_W-1:0]      m_user;

    // predictor state
    logic [OPC_W-1:0]   op_stk [STACK_DEPTH];
    int                 stk_fill    = 0;
    logic [FAULT_W-1:0] first_fault = FAULT_NONE;
    t_postfix_tok       step_out[$];
    t_postfix_tok       postfix_due[$];

    t_infix_tok stim[$];
    t_infix_tok directed_tab [N_DIRECTED];
    int         mismatches   = 0;
    int         items_in     = 0;
    int         results_seen = 0;
    int         marker_cnt [4] = '{0, 0, 0, 0};
    int         cycles       = 0;
    int         sink_hold    = 0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    assign s_data = {{(IN_TDATA_W - TAG_W - OPC_W){1'b0}}, s_tok.op, s_tok.tag};

    infix_to_postfix_converter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_tok.action),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [TAG_W-1:0] rand_tag();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_postfix_tok mk_tok(input logic [KIND_W-1:0] kind,
                                            input logic [TAG_W-1:0] operand,
                                            input logic [OPC_W-1:0] op,
                                            input logic [FAULT_W-1:0] fault,
                                            input logic last);
        return '{kind, operand, op, fault, last};
    endfunction

    function automatic t_infix_tok dir_row(input logic [ACT_W-1:0] action,
                                           input logic [TAG_W-1:0] tag,
                                           input logic [OPC_W-1:0] op,
                                           input logic typed,
                                           input logic [KIND_W-1:0] kind,
                                           input logic [FAULT_W-1:0] fault);
        return '{action, tag, op, typed, kind, fault, 1'b0, 1'b0};
    endfunction

    // append one token, now and then preceded by a stray one
    function automatic void queue_tok(input logic [ACT_W-1:0] action,
                                      input logic [OPC_W-1:0] op, input logic burst);
        t_infix_tok t;
        if ($urandom_range(0, 15) == 0) begin
            t = '0;
            t.action = ACT_W'($urandom_range(0, 3));
            t.op     = OPC_W'($urandom_range(0, 7));
            t.tag    = rand_tag();
            t.no_gap = burst;
            stim.push_back(t);
        end
        t = '0;
        t.action = action;
        t.op     = op;
        t.tag    = rand_tag();
        t.no_gap = burst;
        stim.push_back(t);
    endfunction

    function automatic logic [1:0] bind_rank(input logic [OPC_W-1:0] c);
        if (c == OPC_OPEN) return 2'd1;
        if (c == OPC_ADD || c == OPC_SUB) return 2'd2;
        if (c == OPC_MUL || c == OPC_DIV) return 2'd3;
        return 2'd0;
    endfunction

    function automatic void record_fault(input logic [FAULT_W-1:0] f);
        if (first_fault == FAULT_NONE) first_fault = f;
    endfunction

    function automatic void stack_op(input logic [OPC_W-1:0] c);
        if (stk_fill >= STACK_DEPTH) begin
            record_fault(FAULT_OVERFLOW);
        end else begin
            op_stk[stk_fill] = c;
            stk_fill++;
        end
    endfunction

    function automatic void pop_emit();
        step_out.push_back(mk_tok(KIND_OPERATOR, '0, op_stk[stk_fill-1], FAULT_NONE, 1'b0));
        stk_fill--;
    endfunction

    // shunting-yard step: fills step_out with the results of one token
    function automatic void convert_token(input t_infix_tok t);
        logic [OPC_W-1:0] c;
        t_postfix_tok     r;
        step_out.delete();
        if (t.action == ACT_OPERAND) begin
            step_out.push_back(mk_tok(KIND_OPERAND, t.tag & OPERAND_MASK, '0, FAULT_NONE, 1'b1));
        end else if (t.action == ACT_OPERATOR && t.op <= OPC_DIV) begin
            if (t.op == OPC_OPEN) begin
                stack_op(t.op);
            end else if (t.op == OPC_CLOSE) begin
                while (stk_fill > 0 && op_stk[stk_fill-1] != OPC_OPEN) pop_emit();
                if (stk_fill > 0) stk_fill--;
                else record_fault(FAULT_CLOSE);
            end else begin
                while (stk_fill > 0 && bind_rank(op_stk[stk_fill-1]) >= bind_rank(t.op))
                    pop_emit();
                stack_op(t.op);
            end
            if (step_out.size() > 0) begin
                r = step_out[step_out.size() - 1];
                r.last = 1'b1;
                step_out[step_out.size() - 1] = r;
            end
        end else if (t.action == ACT_END) begin
            while (stk_fill > 0) begin
                c = op_stk[stk_fill-1];
                stk_fill--;
                // a leftover '(' is dropped, never emitted
                if (c == OPC_OPEN) record_fault(FAULT_OPEN);
                else step_out.push_back(mk_tok(KIND_OPERATOR, '0, c, FAULT_NONE, 1'b0));
            end
            step_out.push_back(mk_tok(KIND_MARKER, '0, '0, first_fault, 1'b1));
            first_fault = FAULT_NONE;
        end
    endfunction

    function automatic void flag_mismatch(input string what, input t_postfix_tok got,
                                          input t_postfix_tok want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: got kind=%0d operand=%h op=%0d fault=%0d last=%0b, %s%0d %s%h %s%0d %s%0d %s%0b",
                     $time, what, got.kind, got.operand, got.op, got.fault, got.last,
                     "want kind=", want.kind, "operand=", want.operand, "op=", want.op,
                     "fault=", want.fault, "last=", want.last);
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_postfix_tok got;
        t_postfix_tok want;
        if (rst_n) begin
            if (s_valid && s_ready) begin
                items_in++;
                convert_token(s_tok);
                if (s_tok.typed)
                    postfix_due.push_back(mk_tok(s_tok.t_kind,
                        (s_tok.t_kind == KIND_OPERAND) ? (s_tok.tag & OPERAND_MASK) : '0,
                        '0, s_tok.t_fault, 1'b1));
                else
                    foreach (step_out[k]) postfix_due.push_back(step_out[k]);
            end
            if (m_valid && m_ready) begin
                got = mk_tok(m_user, m_data[TAG_W-1:0], m_data[TAG_W+OPC_W-1:TAG_W],
                             m_data[TAG_W+OPC_W+FAULT_W-1:TAG_W+OPC_W], m_last);
                results_seen++;
                if (got.kind == KIND_MARKER) marker_cnt[got.fault]++;
                if (postfix_due.size() == 0) begin
                    flag_mismatch("result with nothing pending", got, '0);
                end else begin
                    want = postfix_due.pop_front();
                    if (got !== want) flag_mismatch("result mismatch", got, want);
                end
            end
        end
    end

    // output side: alternate ready runs and stalls
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else begin
            m_ready   <= !m_ready;
            sink_hold <= m_ready ? pick_gap()
                       : (($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 4));
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLES) begin
            $display("Run stopped at the cycle limit with %0d results pending",
                     postfix_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_infix_tok t;
        int         gap;
        int         opens;
        int         n_terms;
        int         start;
        logic       burst;

        directed_tab = '{
            dir_row(ACT_END,      32'h0000_0000, OPC_OPEN,  1'b1, KIND_MARKER,  FAULT_NONE),
            dir_row(ACT_OPERAND,  32'h0000_0000, OPC_OPEN,  1'b1, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERAND,  32'hFFFF_FFFF, OPC_BAD7,  1'b1, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERATOR, 32'h0000_0000, OPC_CLOSE, 1'b0, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_END,      32'h0000_0000, OPC_OPEN,  1'b1, KIND_MARKER,  FAULT_CLOSE),
            dir_row(ACT_OPERATOR, 32'h0000_0000, OPC_OPEN,  1'b0, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERAND,  32'h1234_5678, OPC_OPEN,  1'b1, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_END,      32'h0000_0000, OPC_OPEN,  1'b1, KIND_MARKER,  FAULT_OPEN),
            dir_row(ACT_OPERATOR, 32'h0000_0000, OPC_OPEN,  1'b0, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERAND,  32'hA5A5_A5A5, OPC_OPEN,  1'b1, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERATOR, 32'h0000_0000, OPC_ADD,   1'b0, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERAND,  32'h5A5A_5A5A, OPC_OPEN,  1'b1, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERATOR, 32'h0000_0000, OPC_CLOSE, 1'b0, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERATOR, 32'h0000_0000, OPC_MUL,   1'b0, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERAND,  32'h0000_0001, OPC_OPEN,  1'b1, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERATOR, 32'h0000_0000, OPC_SUB,   1'b0, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERAND,  32'h8000_0000, OPC_OPEN,  1'b1, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERATOR, 32'h0000_0000, OPC_DIV,   1'b0, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERATOR, 32'hFFFF_FFFF, OPC_BAD6,  1'b0, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_BAD,      32'hFFFF_FFFF, OPC_BAD7,  1'b0, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERAND,  32'h7FFF_FFFF, OPC_OPEN,  1'b1, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERATOR, 32'h0000_0000, OPC_ADD,   1'b0, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERAND,  32'h0000_0002, OPC_OPEN,  1'b1, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_OPERATOR, 32'h0000_0000, OPC_CLOSE, 1'b0, KIND_OPERAND, FAULT_NONE),
            dir_row(ACT_END,      32'h0000_0000, OPC_OPEN,  1'b1, KIND_MARKER,  FAULT_CLOSE)
        };
        foreach (directed_tab[i]) stim.push_back(directed_tab[i]);

        // deep nesting: run the stack up to full, then push one past it
        start   = stim.size();
        n_terms = STACK_DEPTH / 2 + 1;
        for (int k = 0; k < n_terms; k++) begin
            queue_tok(ACT_OPERATOR, OPC_OPEN, 1'b0);
            queue_tok(ACT_OPERAND, OPC_OPEN, 1'b0);
            queue_tok(ACT_OPERATOR, OPC_W'($urandom_range(OPC_ADD, OPC_DIV)), 1'b0);
        end
        queue_tok(ACT_OPERAND, OPC_OPEN, 1'b0);
        repeat ($urandom_range(0, n_terms + 1)) queue_tok(ACT_OPERATOR, OPC_CLOSE, 1'b0);
        queue_tok(ACT_END, OPC_OPEN, 1'b0);
        t = stim[start];
        t.drain = 1'b1;
        stim[start] = t;

        // random expressions, mostly well formed
        while (stim.size() < N_ITEMS) begin
            start   = stim.size();
            n_terms = $urandom_range(1, 6);
            opens   = 0;
            burst   = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < n_terms; k++) begin
                while ($urandom_range(0, 3) == 0) begin
                    queue_tok(ACT_OPERATOR, OPC_OPEN, burst);
                    opens++;
                end
                queue_tok(ACT_OPERAND, OPC_OPEN, burst);
                while (opens > 0 && $urandom_range(0, 2) == 0) begin
                    queue_tok(ACT_OPERATOR, OPC_CLOSE, burst);
                    opens--;
                end
                if (k < n_terms - 1)
                    queue_tok(ACT_OPERATOR, OPC_W'($urandom_range(OPC_ADD, OPC_DIV)), burst);
            end
            if ($urandom_range(0, 7) != 0)
                repeat (opens) queue_tok(ACT_OPERATOR, OPC_CLOSE, burst);
            else if ($urandom_range(0, 1) == 0)
                queue_tok(ACT_OPERATOR, OPC_CLOSE, burst);
            queue_tok(ACT_END, OPC_OPEN, burst);
            if ($urandom_range(0, 9) == 0) begin
                t = stim[start];
                t.drain = 1'b1;
                stim[start] = t;
            end
        end

        repeat (RST_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;

        foreach (stim[i]) begin
            t   = stim[i];
            gap = t.no_gap ? 0 : pick_gap();
            if (t.drain || gap > 0) begin
                s_valid <= 1'b0;
                if (t.drain) begin
                    // let the scoreboard log the last transfer before looking
                    @(negedge i_clk);
                    while (postfix_due.size() > 0) @(negedge i_clk);
                    @(posedge i_clk);
                end
                repeat (gap) @(posedge i_clk);
            end
            s_valid <= 1'b1;
            s_tok   <= t;
            do @(posedge i_clk); while (!s_ready);
        end
        s_valid <= 1'b0;

        @(negedge i_clk);
        while (postfix_due.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d infix tokens (directed table, deep nesting, random expressions)",
                 items_in);
        $display("Checked %0d postfix results; end markers clean %0d, close %0d, %s %0d, open %0d",
                 results_seen, marker_cnt[FAULT_NONE], marker_cnt[FAULT_CLOSE], "overflow",
                 marker_cnt[FAULT_OVERFLOW], marker_cnt[FAULT_OPEN]);
        if (mismatches == 0 && postfix_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results still pending", mismatches,
                     postfix_due.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
